// File: rtl/particle_ring_pool_update_unit_macros.svh
// ---------------------------------------------------------------------------
// particle_ring_pool_update_unit_macros.svh
// Assertion macros for the particle ring pool; empty bodies for synthesis.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_RING_POOL_UPDATE_UNIT_MACROS_SVH
`define PARTICLE_RING_POOL_UPDATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prp assertion failed");
// next-cycle implication
`define PRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prp assertion failed");
`else
`define PRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/prp_pkg.sv
// ---------------------------------------------------------------------------
// prp_pkg
// Shared widths, command codes and the slot record of the particle pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prp_pkg;

    localparam int MODE_W = 2;
    localparam int POS_W  = 24;
    localparam int VEL_W  = 20;
    localparam int EXT_W  = 16;
    localparam int LIFE_W = 24;
    localparam int RGBA_W = 32;
    localparam int KIND_W = 4;
    localparam int STEP_W = 16;
    // signed vel times zero-extended step
    localparam int PROD_W = VEL_W + STEP_W + 1;

    localparam logic [MODE_W-1:0] MODE_SPAWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [VEL_W-1:0]  vx;
        logic [VEL_W-1:0]  vy;
        logic [EXT_W-1:0]  extent;
        logic [LIFE_W-1:0] life;
        logic [RGBA_W-1:0] rgba;
        logic [KIND_W-1:0] kind;
    } slot_t;

endpackage

// File: rtl/prp_advance.sv
// ---------------------------------------------------------------------------
// prp_advance
// Floors vel*step down to 8 fraction bits and adds it to a position, saturating.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prp_advance import prp_pkg::*;
(
    input  logic signed [POS_W-1:0]  pos,
    input  logic signed [PROD_W-1:0] prod,
    output logic signed [POS_W-1:0]  pos_new
);

    localparam int DELTA_W = PROD_W - STEP_W;
    localparam int SUM_W   = POS_W + 1;

    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;

    // arithmetic drop of the step fraction bits is a floor
    assign delta = $signed(prod[PROD_W-1:STEP_W]);
    assign sum   = SUM_W'(pos) + SUM_W'(delta);

    always_comb
    begin
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            pos_new = sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            pos_new = sum[POS_W-1:0];
        end
    end

endmodule

// File: rtl/particle_ring_pool_update_unit.sv
// Spawn and clear take effect at the accepting edge and never raise busy.
// A tick holds busy while it reads one slot per cycle from the slot memory, then
// steps through the drain states and the finish state for the final (last) result.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset (rst_n, async, active low) clears all active bits, the write index, the FSM.
// ---------------------------------------------------------------------------
// particle_ring_pool_update_unit
// Round-robin particle pool: spawn, clear and a tick that ages every live slot
// and moves and reports every slot that survives.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "particle_ring_pool_update_unit_macros.svh"

module particle_ring_pool_update_unit import prp_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command side
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [VEL_W-1:0]  vel_x,
    input  logic signed [VEL_W-1:0]  vel_y,
    input  logic [EXT_W-1:0]         extent,
    input  logic [LIFE_W-1:0]        lifetime,
    input  logic [RGBA_W-1:0]        rgba,
    input  logic [KIND_W-1:0]        kind,
    input  logic [STEP_W-1:0]        step_time,
    // result side
    output logic                     strobe,
    output logic                     present,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic [EXT_W-1:0]         out_extent,
    output logic [RGBA_W-1:0]        out_rgba,
    output logic [KIND_W-1:0]        out_kind,
    output logic                     last
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // tick sequencer
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic [SLOTS-1:0] active_reg;
    logic [STEP_W-1:0] step_reg;

    // pipeline: stage 1 = memory data out, stage 2 = registered products
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_valid_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    slot_t            s2_slot_reg;
    logic signed [PROD_W-1:0] s2_prod_x_reg;
    logic signed [PROD_W-1:0] s2_prod_y_reg;

    // one survivor is held back so the final one can carry last
    logic             pend_valid_reg;
    slot_t            pend_slot_reg;

    logic             strobe_reg;

    // slot memory, registered read
    slot_t            slot_mem [SLOTS];
    slot_t            rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;
    logic             mem_re;

    logic             accept;
    logic             s1_die;
    slot_t            s1_aged_slot;
    slot_t            spawn_slot;
    slot_t            s2_new_slot;
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // -----------------------------------------------------------------------
    // Stage 1: life test and the two products
    // -----------------------------------------------------------------------
    assign s1_die = (rdata_reg.life <= LIFE_W'(step_reg));
    assign prod_x = PROD_W'($signed(rdata_reg.vx)) * PROD_W'($signed({1'b0, step_reg}));
    assign prod_y = PROD_W'($signed(rdata_reg.vy)) * PROD_W'($signed({1'b0, step_reg}));

    always_comb
    begin
        s1_aged_slot      = rdata_reg;
        s1_aged_slot.life = rdata_reg.life - LIFE_W'(step_reg);
    end

    // -----------------------------------------------------------------------
    // Stage 2: saturating position update and write-back
    // -----------------------------------------------------------------------
    prp_advance u_adv_x
    (
        .pos     ($signed(s2_slot_reg.x)),
        .prod    (s2_prod_x_reg),
        .pos_new (new_x)
    );

    prp_advance u_adv_y
    (
        .pos     ($signed(s2_slot_reg.y)),
        .prod    (s2_prod_y_reg),
        .pos_new (new_y)
    );

    always_comb
    begin
        s2_new_slot   = s2_slot_reg;
        s2_new_slot.x = new_x;
        s2_new_slot.y = new_y;
    end

    always_comb
    begin
        spawn_slot.x      = pos_x;
        spawn_slot.y      = pos_y;
        spawn_slot.vx     = vel_x;
        spawn_slot.vy     = vel_y;
        spawn_slot.extent = extent;
        spawn_slot.life   = lifetime;
        spawn_slot.rgba   = rgba;
        spawn_slot.kind   = kind;
    end

    // Spawn writes only while idle, write-back only during a tick: one port.
    // A tick touches each slot once and busy holds off spawns, so no entry
    // is read while a write to it is still in flight.
    always_comb
    begin
        mem_re = (state_reg == ST_SCAN);
        if (s2_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = s2_idx_reg;
            mem_wdata = s2_new_slot;
        end
        else
        begin
            mem_we    = accept && (mode == MODE_SPAWN);
            mem_waddr = wr_idx_reg;
            mem_wdata = spawn_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[scan_idx_reg];
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            wr_idx_reg     <= '0;
            active_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
            end
            else if (state_reg == ST_IDLE)
            begin
                scan_idx_reg <= '0;
            end

            s1_valid_reg <= (state_reg == ST_SCAN) && active_reg[scan_idx_reg];
            s2_valid_reg <= s1_valid_reg && !s1_die;

            // active bits: spawn sets, clear wipes, an expired slot drops out
            if (accept && (mode == MODE_SPAWN))
            begin
                active_reg[wr_idx_reg] <= 1'b1;
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            end
            else if (accept && (mode == MODE_CLEAR))
            begin
                active_reg <= '0;
                wr_idx_reg <= '0;
            end
            else if (s1_valid_reg && s1_die)
            begin
                active_reg[s1_idx_reg] <= 1'b0;
            end

            if (accept && (mode == MODE_TICK))
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (s2_valid_reg)
            begin
                pend_valid_reg <= 1'b1;
            end

            strobe_reg <= (s2_valid_reg && pend_valid_reg) || (state_reg == ST_FINISH);
        end
    end

    // -----------------------------------------------------------------------
    // Payload registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_TICK))
        begin
            step_reg <= step_time;
        end

        s1_idx_reg <= scan_idx_reg;

        s2_idx_reg           <= s1_idx_reg;
        s2_slot_reg          <= s1_aged_slot;
        s2_prod_x_reg        <= prod_x;
        s2_prod_y_reg        <= prod_y;

        if (s2_valid_reg)
        begin
            pend_slot_reg <= s2_new_slot;
        end

        // a newer survivor pushes the held one out, not last
        if (s2_valid_reg && pend_valid_reg)
        begin
            present    <= 1'b1;
            last       <= 1'b0;
            out_x      <= pend_slot_reg.x;
            out_y      <= pend_slot_reg.y;
            out_extent <= pend_slot_reg.extent;
            out_rgba   <= pend_slot_reg.rgba;
            out_kind   <= pend_slot_reg.kind;
        end
        else if (state_reg == ST_FINISH)
        begin
            // final transaction: held survivor, or an empty marker
            present    <= pend_valid_reg;
            last       <= 1'b1;
            out_x      <= pend_valid_reg ? pend_slot_reg.x : '0;
            out_y      <= pend_valid_reg ? pend_slot_reg.y : '0;
            out_extent <= pend_valid_reg ? pend_slot_reg.extent : '0;
            out_rgba   <= pend_valid_reg ? pend_slot_reg.rgba : '0;
            out_kind   <= pend_valid_reg ? pend_slot_reg.kind : '0;
        end
    end

    assign strobe = strobe_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `PRP_ASSERT_NEXT(a_finish_gives_last, clk, rst_n, state_reg == ST_FINISH, strobe && last)
    `PRP_ASSERT_SAME(a_empty_only_last, clk, rst_n, strobe && !present, last)
    `PRP_ASSERT_NEXT(a_tick_raises_busy, clk, rst_n, accept && (mode == MODE_TICK), busy)
    `PRP_ASSERT_SAME(a_strobe_in_tick, clk, rst_n, strobe && !last, busy)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the particle ring pool: spawn, tick, clear and
// ignored commands go in through start/busy, and every strobed rectangle is
// compared against a shadow copy of the pool kept inside the bench.
// ---------------------------------------------------------------------------

module tb;
    import prp_pkg::*;

    localparam int SLOTS = 64;
    // the package names three command codes; the fourth is accepted and ignored
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX_V = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN_V = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX_V = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN_V = {1'b1, {(VEL_W-1){1'b0}}};

    localparam int RANDOM_ITEMS = 50;
    // trailing wait: a little more than the time a tick keeps busy
    localparam int DRAIN_CYCLES = SLOTS + 8;

    // one command transaction as the bench sees it
    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [VEL_W-1:0]  vx;
        logic signed [VEL_W-1:0]  vy;
        logic [EXT_W-1:0]         ext;
        logic [LIFE_W-1:0]        life;
        logic [RGBA_W-1:0]        rgba;
        logic [KIND_W-1:0]        kind;
        logic [STEP_W-1:0]        step;
    } pool_cmd_t;

    // one strobed rectangle; positions held as raw bit patterns
    typedef struct {
        logic              present;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [EXT_W-1:0]  ext;
        logic [RGBA_W-1:0] rgba;
        logic [KIND_W-1:0] kind;
        logic              last;
    } rect_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [MODE_W-1:0]       mode = MODE_SPAWN;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [VEL_W-1:0] vel_x = '0;
    logic signed [VEL_W-1:0] vel_y = '0;
    logic [EXT_W-1:0]        extent = '0;
    logic [LIFE_W-1:0]       lifetime = '0;
    logic [RGBA_W-1:0]       rgba = '0;
    logic [KIND_W-1:0]       kind = '0;
    logic [STEP_W-1:0]       step_time = '0;
    logic                    strobe;
    logic                    present;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [EXT_W-1:0]        out_extent;
    logic [RGBA_W-1:0]       out_rgba;
    logic [KIND_W-1:0]       out_kind;
    logic                    last;

    // shadow pool: slot records, active flags and the round-robin write index
    slot_t       pool [SLOTS];
    bit          live [SLOTS];
    int unsigned wr_slot = 0;

    // rectangles predicted but not yet seen on the result side, oldest first
    rect_t expected_rects [$];
    rect_t want;
    int    errors = 0;

    // sender pacing: bursts of back-to-back transactions separated by gaps
    bit gaps_on = 1'b1;
    int burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    particle_ring_pool_update_unit #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .extent     (extent),
        .lifetime   (lifetime),
        .rgba       (rgba),
        .kind       (kind),
        .step_time  (step_time),
        .strobe     (strobe),
        .present    (present),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_extent (out_extent),
        .out_rgba   (out_rgba),
        .out_kind   (out_kind),
        .last       (last)
    );

    // -----------------------------------------------------------------------
    // Shadow pool
    // -----------------------------------------------------------------------

    // Move one axis: floor(vel * step / 2^16) keeps 8 fraction bits, then a
    // saturating add into the signed 24-bit position range.
    function automatic logic [POS_W-1:0] move_axis(
        input logic signed [POS_W-1:0] pos,
        input logic signed [VEL_W-1:0] vel,
        input logic [STEP_W-1:0]       step
    );
        longint delta;
        longint sum;
        delta = (longint'(vel) * longint'(step)) >>> 16;
        sum = longint'(pos) + delta;
        if (sum > longint'(POS_MAX_V))
            sum = longint'(POS_MAX_V);
        if (sum < longint'(POS_MIN_V))
            sum = longint'(POS_MIN_V);
        return POS_W'(sum);
    endfunction

    // Apply one accepted command to the shadow pool and queue the rectangles
    // that a tick will strobe out.
    function automatic void update_pool(input pool_cmd_t c);
        rect_t batch [$];
        rect_t r;
        case (c.mode)
            MODE_SPAWN:
            begin
                pool[wr_slot].x      = c.px;
                pool[wr_slot].y      = c.py;
                pool[wr_slot].vx     = c.vx;
                pool[wr_slot].vy     = c.vy;
                pool[wr_slot].extent = c.ext;
                pool[wr_slot].life   = c.life;
                pool[wr_slot].rgba   = c.rgba;
                pool[wr_slot].kind   = c.kind;
                live[wr_slot] = 1'b1;
                wr_slot = (wr_slot + 1) % SLOTS;
            end
            MODE_CLEAR:
            begin
                foreach (live[i])
                    live[i] = 1'b0;
                wr_slot = 0;
            end
            MODE_TICK:
            begin
                // ascending slot order; a life at or below the step dies silently
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (live[i])
                    begin
                        if (pool[i].life <= c.step)
                        begin
                            live[i] = 1'b0;
                        end
                        else
                        begin
                            pool[i].life = pool[i].life - c.step;
                            pool[i].x = move_axis(pool[i].x, pool[i].vx, c.step);
                            pool[i].y = move_axis(pool[i].y, pool[i].vy, c.step);
                            r.present = 1'b1;
                            r.x       = pool[i].x;
                            r.y       = pool[i].y;
                            r.ext     = pool[i].extent;
                            r.rgba    = pool[i].rgba;
                            r.kind    = pool[i].kind;
                            r.last    = 1'b0;
                            batch.push_back(r);
                        end
                    end
                end
                // no survivors: one all-zero result flagged last
                if (batch.size() == 0)
                begin
                    r = '{default: '0};
                    r.last = 1'b1;
                    batch.push_back(r);
                end
                else
                begin
                    batch[batch.size() - 1].last = 1'b1;
                end
                foreach (batch[i])
                    expected_rects.push_back(batch[i]);
            end
            default:
            begin
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------

    function automatic void check_field(
        input string       name,
        input logic [31:0] want_v,
        input logic [31:0] got_v
    );
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    // Results cannot be held off, so every strobed cycle is one transaction.
    // Outputs are sampled at the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (expected_rects.size() == 0)
            begin
                $display("%0t: result with nothing expected, x %h y %h last %b",
                         $time, out_x, out_y, last);
                errors++;
            end
            else
            begin
                want = expected_rects.pop_front();
                check_field("present", want.present, present);
                check_field("out_x", want.x, $unsigned(out_x));
                check_field("out_y", want.y, $unsigned(out_y));
                check_field("out_extent", want.ext, out_extent);
                check_field("out_rgba", want.rgba, out_rgba);
                check_field("out_kind", want.kind, out_kind);
                check_field("last", want.last, last);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Mostly uniform, sometimes close to either saturation rail.
    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 7))
            0: return POS_W'($urandom_range(32'h007F_F000, 32'h007F_FFFF));
            1: return POS_W'($urandom_range(32'h0080_0000, 32'h0080_0FFF));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Random payload for any mode. Lives and steps are skewed so that slots
    // both die quickly and survive many ticks.
    function automatic pool_cmd_t random_fields(input logic [MODE_W-1:0] m);
        pool_cmd_t c;
        c.mode = m;
        c.px   = pick_pos();
        c.py   = pick_pos();
        c.vx   = VEL_W'($urandom);
        c.vy   = VEL_W'($urandom);
        c.ext  = EXT_W'($urandom);
        c.rgba = $urandom;
        c.kind = KIND_W'($urandom);
        case ($urandom_range(0, 3))
            0: c.life = LIFE_W'($urandom_range(0, 32'h0003_0000));
            1: c.life = LIFE_W'($urandom);
            default: c.life = LIFE_W'($urandom_range(32'h0001_0000, 32'h0040_0000));
        endcase
        case ($urandom_range(0, 7))
            0: c.step = '0;
            1: c.step = '1;
            2: c.step = STEP_W'($urandom_range(1, 32'h400));
            default: c.step = STEP_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic pool_cmd_t spawn_at(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y,
        input logic signed [VEL_W-1:0] vx,
        input logic signed [VEL_W-1:0] vy,
        input logic [LIFE_W-1:0]       life
    );
        pool_cmd_t c;
        c = random_fields(MODE_SPAWN);
        c.px   = x;
        c.py   = y;
        c.vx   = vx;
        c.vy   = vy;
        c.life = life;
        return c;
    endfunction

    function automatic pool_cmd_t tick_by(input logic [STEP_W-1:0] step);
        pool_cmd_t c;
        c = random_fields(MODE_TICK);
        c.step = step;
        return c;
    endfunction

    // Drive one command transaction and wait for it to be taken. start is left
    // high on return so the next transaction of a burst follows without a
    // bubble; gaps lower it in a later time step.
    task automatic send_cmd(input pool_cmd_t c);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        mode      <= c.mode;
        pos_x     <= c.px;
        pos_y     <= c.py;
        vel_x     <= c.vx;
        vel_y     <= c.vy;
        extent    <= c.ext;
        lifetime  <= c.life;
        rgba      <= c.rgba;
        kind      <= c.kind;
        step_time <= c.step;
        start     <= 1'b1;
        // taken at the first edge that sees start high and busy low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        update_pool(c);
    endtask

    // Hold the sender off until every predicted rectangle has been seen.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_rects.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Tick on a pool that was never filled: one empty result flagged last.
    task automatic test_empty_tick();
        send_cmd(random_fields(MODE_TICK));
    endtask

    // Both rails in both directions, widest payload values, and the floor
    // rounding of a tiny negative move.
    task automatic test_saturation();
        pool_cmd_t c;
        c = spawn_at(POS_MAX_V, POS_MIN_V, VEL_MAX_V, VEL_MIN_V, '1);
        c.ext  = '1;
        c.rgba = '1;
        c.kind = '1;
        send_cmd(c);
        c = spawn_at(POS_MIN_V, POS_MAX_V, VEL_MIN_V, VEL_MAX_V, '1);
        c.ext  = '0;
        c.rgba = '0;
        c.kind = '0;
        send_cmd(c);
        // vx of -1 must step x down by one LSB, vy of +1 must not move y
        send_cmd(spawn_at('0, '0, '1, VEL_W'(1), '1));
        send_cmd(tick_by(STEP_W'(1)));
        send_cmd(tick_by('1));
        send_cmd(random_fields(MODE_CLEAR));
    endtask

    // Death boundary: a life equal to the step dies, one above survives.
    task automatic test_life_edges();
        pool_cmd_t c;
        c = random_fields(MODE_SPAWN);
        c.life = '0;
        send_cmd(c);
        // zero step still kills a zero life
        send_cmd(tick_by('0));
        c = random_fields(MODE_SPAWN);
        c.life = LIFE_W'(100);
        send_cmd(c);
        send_cmd(tick_by(STEP_W'(100)));
        c = random_fields(MODE_SPAWN);
        c.life = LIFE_W'(101);
        send_cmd(c);
        send_cmd(tick_by(STEP_W'(100)));
        send_cmd(tick_by('0));
        send_cmd(tick_by(STEP_W'(1)));
    endtask

    // Ignored code leaves the pool alone; clear empties it.
    task automatic test_clear_and_nop();
        send_cmd(random_fields(MODE_SPAWN));
        send_cmd(random_fields(MODE_SPAWN));
        send_cmd(random_fields(MODE_NOP));
        send_cmd(tick_by(STEP_W'($urandom_range(0, 32'h100))));
        send_cmd(random_fields(MODE_CLEAR));
        send_cmd(random_fields(MODE_TICK));
    endtask

    // Clear must rewind the write index: after it, SLOTS+3 spawns wrap and
    // overwrite slots 0..2, which shows up in the order of the full tick.
    task automatic test_wrap_after_clear();
        pool_cmd_t c;
        repeat (3)
            send_cmd(random_fields(MODE_SPAWN));
        send_cmd(random_fields(MODE_CLEAR));
        repeat (SLOTS + 3)
        begin
            c = random_fields(MODE_SPAWN);
            c.life = LIFE_W'($urandom_range(32'h0010_0000, 32'h00FF_FFFF));
            send_cmd(c);
        end
        send_cmd(random_fields(MODE_TICK));
        send_cmd(random_fields(MODE_TICK));
    endtask

    // Mixed traffic. A stretch in the middle runs back to back, and now and
    // then the sender waits for the pool to report everything.
    task automatic test_random_traffic();
        int done;
        int pick;
        pool_cmd_t c;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            gaps_on = !(done >= RANDOM_ITEMS / 3 && done < RANDOM_ITEMS / 2);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                c = random_fields(MODE_SPAWN);
            else if (pick < 88)
                c = random_fields(MODE_TICK);
            else if (pick < 93)
                c = random_fields(MODE_CLEAR);
            else
                c = random_fields(MODE_NOP);
            send_cmd(c);
            if (c.mode != MODE_NOP)
                done++;
            if (done == RANDOM_ITEMS / 2 || $urandom_range(0, 24) == 0)
                drain_results();
        end
        gaps_on = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_tick();
        test_saturation();
        test_life_edges();
        test_clear_and_nop();
        test_wrap_after_clear();
        test_random_traffic();
        drain_results();
        // let any trailing activity show up as an unexpected result
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_rects.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
